FILE: hdl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int VALUE_W    = 64;
  localparam int COUNT_BITS = 16;
  localparam int CONSUMED_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SELECT = 1'b1;

  // width_select codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_POSTSIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  function automatic logic [VALUE_W-1:0] width_mask(input logic [1:0] wsel);
    logic [VALUE_W-1:0] m;
    case (wsel)
      WSEL_8:  m = VALUE_W'(64'h0000_0000_0000_00FF);
      WSEL_16: m = VALUE_W'(64'h0000_0000_0000_FFFF);
      WSEL_32: m = VALUE_W'(64'h0000_0000_FFFF_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/aip_accum.sv
// ----------------------------------------------------------------------------
// aip_accum
// Digit decode and one shift-add step of the accumulator in base 10 or 16.
// ----------------------------------------------------------------------------
module aip_accum (
  input  logic [7:0]                   character,
  input  logic                         hex_mode,
  input  logic [1:0]                   width_select,
  input  logic [aip_pkg::VALUE_W-1:0]  acc,
  output logic                         is_digit,
  output logic [aip_pkg::VALUE_W-1:0]  acc_step
);

  logic [3:0]                  digit;
  logic [aip_pkg::VALUE_W-1:0] scaled;

  always_comb begin
    is_digit = 1'b0;
    digit    = 4'd0;
    if (character inside {[aip_pkg::CH_ZERO:aip_pkg::CH_NINE]}) begin
      is_digit = 1'b1;
      digit    = 4'(character - aip_pkg::CH_ZERO);
    end else if (hex_mode && (character inside {[aip_pkg::CH_UA:aip_pkg::CH_UF]})) begin
      is_digit = 1'b1;
      digit    = 4'(character - aip_pkg::CH_UA) + 4'd10;
    end else if (hex_mode && (character inside {[aip_pkg::CH_LA:aip_pkg::CH_LF]})) begin
      is_digit = 1'b1;
      digit    = 4'(character - aip_pkg::CH_LA) + 4'd10;
    end
  end

  // times 16 is a shift, times 10 is 8x + 2x
  assign scaled   = hex_mode ? (acc << 4) : ((acc << 3) + (acc << 1));
  assign acc_step = (scaled + aip_pkg::VALUE_W'(digit)) & aip_pkg::width_mask(width_select);

endmodule

FILE: hdl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming atoi: one ASCII character per request, one integer per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (char_valid / char_stall) carries one character per
//   request, with no_char for an empty end marker and last on the final
//   request of a buffer. One character is taken every cycle unless a result
//   is parked in the spare register behind the result register.
//   The result channel (result_valid / result_stall) gives one request per
//   buffer: value, ok and consumed. It is registered from the request that ends
//   the parse (a non-digit or the last request), via the spare register if held.
//   Throughput is one character per cycle while char_stall is low; the
//   combinational shift-add on the accumulator is the step that sets it.
//   When a result is held by result_stall and another one is pending,
//   char_stall rises and the input waits; otherwise input keeps flowing.
//   The configuration channel (cfg_valid / cfg_ready) is always ready; the user
//   must write it only between buffers; the block itself does not enforce this.
//   Reset clears the parse state, signed_mode to 0, width_select to 64 bits,
//   and drops any pending result.
// ----------------------------------------------------------------------------
module ascii_integer_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic [7:0]                      character,
  input  logic                            no_char,
  input  logic                            last,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [aip_pkg::VALUE_W-1:0]     value,
  output logic                            ok,
  output logic [aip_pkg::CONSUMED_W-1:0]  consumed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aip_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic       signed_mode;
  logic [1:0] width_select;

  aip_pkg::phase_t                phase, phase_next;
  logic                           hex_mode, hex_mode_next;
  logic                           negative, negative_next;
  logic [aip_pkg::VALUE_W-1:0]    accumulator, accumulator_next;
  logic                           digit_seen, digit_seen_next;
  logic [aip_pkg::COUNT_BITS-1:0] consumed_count, consumed_count_next;

  logic                           res_negative;
  logic                           res_signed;
  logic [1:0]                     res_width;
  logic [aip_pkg::VALUE_W-1:0]    res_acc;

  logic                           spare_valid;
  logic                           spare_negative;
  logic                           spare_signed;
  logic [1:0]                     spare_width;
  logic [aip_pkg::VALUE_W-1:0]    spare_acc;
  logic                           spare_ok;
  logic [aip_pkg::CONSUMED_W-1:0] spare_consumed;

  logic                           accept;
  logic                           emit;
  logic                           out_free;
  logic                           is_digit;
  logic                           is_space;
  logic [aip_pkg::VALUE_W-1:0]    acc_step;
  logic [aip_pkg::COUNT_BITS-1:0] count_inc;

  logic [aip_pkg::VALUE_W-1:0]    emit_acc;
  logic                           emit_neg;
  logic                           emit_seen;
  logic [aip_pkg::COUNT_BITS-1:0] emit_count;

  assign cfg_ready  = 1'b1;
  assign char_stall = spare_valid;
  assign accept     = char_valid && !char_stall;
  assign out_free   = !result_valid || !result_stall;

  aip_accum u_accum (
    .character    (character),
    .hex_mode     (hex_mode),
    .width_select (width_select),
    .acc          (accumulator),
    .is_digit     (is_digit),
    .acc_step     (acc_step)
  );

  assign is_space  = character inside {aip_pkg::CH_SPACE, [aip_pkg::CH_TAB:aip_pkg::CH_CR]};
  assign count_inc = (consumed_count != aip_pkg::COUNT_MAX)
                     ? consumed_count + aip_pkg::COUNT_BITS'(1)
                     : consumed_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode  <= 1'b0;
      width_select <= aip_pkg::WSEL_64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aip_pkg::CFG_SIGNED_MODE:  signed_mode  <= cfg_data[0];
        aip_pkg::CFG_WIDTH_SELECT: width_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= aip_pkg::PH_LEAD;
      hex_mode       <= 1'b0;
      negative       <= 1'b0;
      accumulator    <= '0;
      digit_seen     <= 1'b0;
      consumed_count <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      hex_mode       <= hex_mode_next;
      negative       <= negative_next;
      accumulator    <= accumulator_next;
      digit_seen     <= digit_seen_next;
      consumed_count <= consumed_count_next;
    end
  end

  always_comb begin
    logic term;
    term                = 1'b0;
    emit                = 1'b0;
    phase_next          = phase;
    hex_mode_next       = hex_mode;
    negative_next       = negative;
    accumulator_next    = accumulator;
    digit_seen_next     = digit_seen;
    consumed_count_next = consumed_count;

    if (!no_char) begin
      case (phase)
        aip_pkg::PH_LEAD, aip_pkg::PH_POSTSIGN: begin
          if (is_space) begin
            consumed_count_next = count_inc;
          end else if (phase == aip_pkg::PH_LEAD && character == aip_pkg::CH_MINUS
                       && signed_mode) begin
            negative_next       = 1'b1;
            consumed_count_next = count_inc;
            phase_next          = aip_pkg::PH_POSTSIGN;
          end else if (character == aip_pkg::CH_ZERO) begin
            accumulator_next    = '0;
            digit_seen_next     = 1'b1;
            consumed_count_next = count_inc;
            phase_next          = aip_pkg::PH_ZERO;
          end else if (is_digit) begin
            accumulator_next    = acc_step;
            digit_seen_next     = 1'b1;
            consumed_count_next = count_inc;
            phase_next          = aip_pkg::PH_DIGITS;
          end else begin
            phase_next = aip_pkg::PH_DONE;
            term       = 1'b1;
          end
        end
        aip_pkg::PH_ZERO, aip_pkg::PH_DIGITS: begin
          if (phase == aip_pkg::PH_ZERO
              && (character == aip_pkg::CH_LX || character == aip_pkg::CH_UX)) begin
            hex_mode_next       = 1'b1;
            digit_seen_next     = 1'b0;
            consumed_count_next = count_inc;
            phase_next          = aip_pkg::PH_DIGITS;
          end else if (is_digit) begin
            accumulator_next    = acc_step;
            digit_seen_next     = 1'b1;
            consumed_count_next = count_inc;
            phase_next          = aip_pkg::PH_DIGITS;
          end else begin
            phase_next = aip_pkg::PH_DONE;
            term       = 1'b1;
          end
        end
        default: ;
      endcase
    end

    emit = term || (last && phase_next != aip_pkg::PH_DONE);

    // the result takes the post-step state, before the end-of-buffer clear
    emit_acc   = accumulator_next;
    emit_neg   = negative_next;
    emit_seen  = digit_seen_next;
    emit_count = consumed_count_next;

    // end of buffer: drop all parse state
    if (last) begin
      phase_next          = aip_pkg::PH_LEAD;
      hex_mode_next       = 1'b0;
      negative_next       = 1'b0;
      accumulator_next    = '0;
      digit_seen_next     = 1'b0;
      consumed_count_next = '0;
    end
  end

  // result register with a spare behind it; park a new result in the spare
  // while the result register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else if (out_free) begin
      result_valid <= spare_valid || (accept && emit);
      spare_valid  <= 1'b0;
    end else if (accept && emit) begin
      spare_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && spare_valid) begin
      res_acc      <= spare_acc;
      res_negative <= spare_negative;
      res_signed   <= spare_signed;
      res_width    <= spare_width;
      ok           <= spare_ok;
      consumed     <= spare_consumed;
    end else if (out_free && accept && emit) begin
      res_acc      <= emit_acc & aip_pkg::width_mask(width_select);
      res_negative <= emit_neg;
      res_signed   <= signed_mode;
      res_width    <= width_select;
      ok           <= emit_seen;
      consumed     <= aip_pkg::CONSUMED_W'(emit_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!out_free && accept && emit) begin
      spare_acc      <= emit_acc & aip_pkg::width_mask(width_select);
      spare_negative <= emit_neg;
      spare_signed   <= signed_mode;
      spare_width    <= width_select;
      spare_ok       <= emit_seen;
      spare_consumed <= aip_pkg::CONSUMED_W'(emit_count);
    end
  end

  // negate and sign-extend from the captured width
  always_comb begin
    logic [aip_pkg::VALUE_W-1:0] mask;
    logic [aip_pkg::VALUE_W-1:0] v;
    logic                        sign;
    mask = aip_pkg::width_mask(res_width);
    v    = res_negative ? ((~res_acc + aip_pkg::VALUE_W'(1)) & mask) : res_acc;
    case (res_width)
      aip_pkg::WSEL_8:  sign = v[7];
      aip_pkg::WSEL_16: sign = v[15];
      aip_pkg::WSEL_32: sign = v[31];
      default:          sign = 1'b0;
    endcase
    if (res_signed && sign) begin
      v = v | ~mask;
    end
    value = v;
  end

endmodule

FILE: bench/aip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_checker
// Watches the character, result and register channels of the ASCII integer
// parser, predicts each result from the accepted characters and compares it
// field by field with what the parser returns.
// ----------------------------------------------------------------------------
module aip_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  input  logic                            char_stall,
  input  logic [7:0]                      character,
  input  logic                            no_char,
  input  logic                            last,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [aip_pkg::VALUE_W-1:0]     value,
  input  logic                            ok,
  input  logic [aip_pkg::CONSUMED_W-1:0]  consumed,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [aip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aip_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              results_due
);

  typedef struct packed {
    logic [aip_pkg::VALUE_W-1:0]    value;
    logic                           ok;
    logic [aip_pkg::CONSUMED_W-1:0] consumed;
  } parse_result_t;

  parse_result_t parse_results[$];

  // register copies
  logic       neg_allowed;
  logic [1:0] wsel;

  // parse state
  aip_pkg::phase_t                ph;
  logic                           hex_digits;
  logic                           minus_taken;
  logic [aip_pkg::VALUE_W-1:0]    acc;
  logic                           digit_taken;
  logic [aip_pkg::COUNT_BITS-1:0] taken_count;

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  function automatic logic [aip_pkg::VALUE_W-1:0] mask_of(input logic [1:0] w);
    if (w == aip_pkg::WSEL_64) return '1;
    return (64'd1 << (8 << w)) - 64'd1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == aip_pkg::CH_SPACE || (c >= aip_pkg::CH_TAB && c <= aip_pkg::CH_CR);
  endfunction

  function automatic int digit_of(input logic [7:0] c);
    if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE) return int'(c - aip_pkg::CH_ZERO);
    if (hex_digits) begin
      if (c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF) return int'(c - aip_pkg::CH_UA) + 10;
      if (c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF) return int'(c - aip_pkg::CH_LA) + 10;
    end
    return -1;
  endfunction

  task automatic clear_parse();
    ph          = aip_pkg::PH_LEAD;
    hex_digits  = 1'b0;
    minus_taken = 1'b0;
    acc         = '0;
    digit_taken = 1'b0;
    taken_count = '0;
  endtask

  task automatic bump_count();
    if (taken_count != aip_pkg::COUNT_MAX)
      taken_count = taken_count + aip_pkg::COUNT_BITS'(1);
  endtask

  task automatic take_zero();
    acc         = '0;
    digit_taken = 1'b1;
    bump_count();
    ph = aip_pkg::PH_ZERO;
  endtask

  task automatic shift_digit(input logic [7:0] c, output bit ended);
    int d;
    d = digit_of(c);
    ended = 1'b0;
    if (d < 0) begin
      ph    = aip_pkg::PH_DONE;
      ended = 1'b1;
    end else begin
      acc = (acc * (hex_digits ? 64'd16 : 64'd10) + 64'(d)) & mask_of(wsel);
      digit_taken = 1'b1;
      bump_count();
      ph = aip_pkg::PH_DIGITS;
    end
  endtask

  task automatic queue_result();
    parse_result_t               r;
    logic [aip_pkg::VALUE_W-1:0] m;
    logic [aip_pkg::VALUE_W-1:0] v;
    int                          b;
    m = mask_of(wsel);
    b = 8 << wsel;
    v = acc & m;
    if (minus_taken) v = (-v) & m;
    if (neg_allowed && b < 64 && v[b-1]) v = v | ~m;
    r.value    = v;
    r.ok       = digit_taken;
    r.consumed = taken_count;
    parse_results.push_back(r);
  endtask

  task automatic predict_item(input logic [7:0] c, input logic nc, input logic lst);
    bit fired;
    fired = 1'b0;
    if (nc) begin
      if (lst) begin
        if (ph != aip_pkg::PH_DONE) queue_result();
        clear_parse();
      end
    end else begin
      case (ph)
        aip_pkg::PH_LEAD, aip_pkg::PH_POSTSIGN: begin
          if (is_blank(c)) bump_count();
          else if (ph == aip_pkg::PH_LEAD && c == aip_pkg::CH_MINUS && neg_allowed) begin
            minus_taken = 1'b1;
            bump_count();
            ph = aip_pkg::PH_POSTSIGN;
          end else if (c == aip_pkg::CH_ZERO) take_zero();
          else shift_digit(c, fired);
        end
        aip_pkg::PH_ZERO: begin
          if (c == aip_pkg::CH_LX || c == aip_pkg::CH_UX) begin
            hex_digits  = 1'b1;
            digit_taken = 1'b0;
            bump_count();
            ph = aip_pkg::PH_DIGITS;
          end else shift_digit(c, fired);
        end
        aip_pkg::PH_DIGITS: shift_digit(c, fired);
        default: ;
      endcase
      if (fired) queue_result();
      if (lst) begin
        if (!fired && ph != aip_pkg::PH_DONE) queue_result();
        clear_parse();
      end
    end
  endtask

  always @(posedge clk) begin
    parse_result_t exp_r;
    if (rst) begin
      neg_allowed = 1'b0;
      wsel        = aip_pkg::WSEL_64;
      clear_parse();
      parse_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (parse_results.size() == 0) begin
          $display("%0t: result with none expected: value %h ok %0d consumed %0d",
                   $time, value, ok, consumed);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = parse_results.pop_front();
          if (value !== exp_r.value || ok !== exp_r.ok || consumed !== exp_r.consumed) begin
            if (value !== exp_r.value)
              $display("%0t: value mismatch: expected %h, actual %h",
                       $time, exp_r.value, value);
            if (ok !== exp_r.ok)
              $display("%0t: ok mismatch: expected %0d, actual %0d", $time, exp_r.ok, ok);
            if (consumed !== exp_r.consumed)
              $display("%0t: consumed mismatch: expected %0d, actual %0d",
                       $time, exp_r.consumed, consumed);
            fail_count <= fail_count + 1;
          end
        end
      end
      // characters see the registers as they were before this edge
      if (char_valid && !char_stall) predict_item(character, no_char, last);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == aip_pkg::CFG_SIGNED_MODE) neg_allowed = cfg_data[0];
        else if (cfg_index == aip_pkg::CFG_WIDTH_SELECT) wsel = cfg_data[1:0];
      end
    end
    results_due <= parse_results.size();
  end

endmodule

FILE: bench/tb_ascii_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_integer_parser
// Drives text buffers into the ASCII integer parser under random idling and
// result back-pressure, across signed/unsigned modes and all result widths,
// and reports the verdict from the checker's failure count, failing also at the cycle limit.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LG      = 8'h67;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           char_valid = 1'b0;
  logic                           char_stall;
  logic [7:0]                     character = '0;
  logic                           no_char = 1'b0;
  logic                           last = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [aip_pkg::VALUE_W-1:0]    value;
  logic                           ok;
  logic [aip_pkg::CONSUMED_W-1:0] consumed;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [aip_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [aip_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int results_due;

  int  cycle_count = 0;
  int  items_sent  = 0;
  bit  calm        = 1'b0;
  bit  cur_signed  = 1'b0;
  int  hold_req    = 0;
  int  hold_seen   = 0;
  int  hold_left   = 0;
  int  stall_left  = 0;

  logic [7:0] text_buf[$];

  ascii_integer_parser dut (.*);

  aip_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result back-pressure; a long hold is started by bumping hold_req
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= 1'b1;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 3);
    end
  end

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return aip_pkg::CH_SPACE;
      1: return aip_pkg::CH_TAB;
      2: return CH_NEWLINE;
      3: return CH_VTAB;
      4: return CH_FFEED;
      default: return aip_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(aip_pkg::CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? aip_pkg::CH_UA : aip_pkg::CH_LA) + v - 10);
  endfunction

  task automatic send_item(input logic [7:0] c, input logic nc, input logic lst);
    int g;
    char_valid <= 1'b1;
    character  <= c;
    no_char    <= nc;
    last       <= lst;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    items_sent++;
    g = idle_gap();
    if (g > 0) begin
      char_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit with_last);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0, with_last && i == s.len() - 1);
  endtask

  // hold the sender until every expected result is back, then let the pipe empty
  task automatic wait_drain();
    char_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aip_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_mode(input bit sgn, input logic [1:0] wsel);
    // upper data bit is don't-care for the sign register
    write_reg(aip_pkg::CFG_SIGNED_MODE, {1'($urandom_range(0, 1)), sgn});
    write_reg(aip_pkg::CFG_WIDTH_SELECT, wsel);
    cfg_valid  <= 1'b0;
    cur_signed  = sgn;
  endtask

  task automatic send_random_buffer();
    int  kind;
    int  n;
    bit  hex;
    bit  marker;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise
      n = $urandom_range(1, 8);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 17) begin
      repeat ($urandom_range(0, 3)) text_buf.push_back(blank_char());
      if ((cur_signed && $urandom_range(0, 2) == 0) || $urandom_range(0, 19) == 0) begin
        text_buf.push_back(aip_pkg::CH_MINUS);
        repeat ($urandom_range(0, 2)) text_buf.push_back(blank_char());
        if ($urandom_range(0, 15) == 0) text_buf.push_back(aip_pkg::CH_MINUS);
      end
      hex = ($urandom_range(0, 2) == 0);
      if (hex) begin
        text_buf.push_back(aip_pkg::CH_ZERO);
        text_buf.push_back($urandom_range(0, 1) ? aip_pkg::CH_LX : aip_pkg::CH_UX);
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (n)
        text_buf.push_back(hex ? hex_char() : 8'(aip_pkg::CH_ZERO + $urandom_range(0, 9)));
      case ($urandom_range(0, 5))
        0, 1: ;
        2: text_buf.push_back(blank_char());
        3: text_buf.push_back(CH_SEMI);
        4: text_buf.push_back($urandom_range(0, 1) ? CH_LG : aip_pkg::CH_LX);
        default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
    // kinds 12..16 leave the buffer empty: a bare end marker
    marker = (text_buf.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (text_buf[i]) begin
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      send_item(text_buf[i], 1'b0, !marker && i == text_buf.size() - 1);
    end
    if (marker) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  initial begin
    bit         sgn_plan[6];
    logic [1:0] wsel_plan[6];
    int         phase_idx;
    int         phase_end;

    sgn_plan  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    wsel_plan = '{aip_pkg::WSEL_64, aip_pkg::WSEL_8, aip_pkg::WSEL_8,
                  aip_pkg::WSEL_64, aip_pkg::WSEL_16, aip_pkg::WSEL_32};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: unsigned, 64 bits
    send_text(" 0", 1'b1);               // lone zero at the end
    send_item(8'h00, 1'b1, 1'b1);        // empty buffer
    send_text("0x", 1'b1);               // bare prefix
    send_text("0XaF", 1'b1);             // hex letters, both cases
    send_text("-5", 1'b1);               // minus is a non-digit when unsigned
    send_text("\t9", 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);        // marker without last: ignored
    send_item(8'h00, 1'b1, 1'b1);        // end marker gives the result
    send_text("7;", 1'b1);               // terminator that is also last
    send_text("8 ", 1'b0);
    send_item(8'h00, 1'b1, 1'b1);        // result already given: nothing
    wait_drain();
    set_mode(1'b1, aip_pkg::WSEL_8);
    send_text("- 9a", 1'b1);             // negative, sign-extended from 8 bits

    items_sent = 0;
    phase_idx  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drain();
      if (phase_idx < 6) set_mode(sgn_plan[phase_idx], wsel_plan[phase_idx]);
      else set_mode(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      calm <= (phase_idx % 5 == 2);
      phase_end = items_sent + PHASE_ITEMS;
      if (phase_idx == 3) begin
        // keep offering while results are held so the input backs up
        hold_req <= hold_req + 1;
        repeat (40) send_random_buffer();
      end
      while (items_sent < phase_end) send_random_buffer();
      phase_idx++;
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/aip_pkg.sv
hdl/aip_accum.sv
hdl/ascii_integer_parser.sv
bench/aip_checker.sv
bench/tb_ascii_integer_parser.sv
